[rtl/core/sorted_key_table_defines.svh]
// Assertion macros used by the sorted key table top level.
`ifndef SORTED_KEY_TABLE_DEFINES_SVH
`define SORTED_KEY_TABLE_DEFINES_SVH

// Checks a property on every rising edge of clk while reset is released.
`define SKT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks a property on every rising edge of clk, reset included.
`define SKT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/skt_pkg.sv]
// Types and constants of the sorted key table.
package skt_pkg;

	localparam int KEY_W     = 32;
	localparam int PAYLOAD_W = 32;
	localparam int STATUS_W  = 3;
	localparam int COUNT_W   = 7;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_DELETE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture; // latch the request and the compare masks
		logic apply;   // update the table and the result registers
	} skt_cmd_t;

endpackage

[rtl/core/sorted_key_table.sv]
// Top level of the sorted key table: controller plus register array datapath.
//
//   channel   direction  handshake             fields
//   request   in         start and not busy    req_type, key, payload
//   result    out        done (one cycle)      status, entry_count
//
// An item is accepted at the edge where start is high and busy is low. In the
// next cycle busy is high while the registered compare masks of all entries
// pick the insert or delete position and the array shifts in one step.
// The result appears in the cycle after that, for exactly one cycle under done,
// and a new item may be accepted in that same cycle, though never while busy.
// arst_n clears the entry count and the controller; stored entries are not
// cleared, since only entries below the count are ever used.
// The receiver cannot stall; results are never held back.
`include "sorted_key_table_defines.svh"

module sorted_key_table #(
	parameter int CAPACITY = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            req_type,
	input  logic [skt_pkg::KEY_W-1:0]       key,
	input  logic [skt_pkg::PAYLOAD_W-1:0]   payload,
	output logic                            done,
	output logic [skt_pkg::STATUS_W-1:0]    status,
	output logic [skt_pkg::COUNT_W-1:0]     entry_count
);
	import skt_pkg::*;

	skt_cmd_t cmd;

	// The controller sequences capture and apply; it sees only start.
	skt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// The datapath holds the sorted entries and the result registers.
	skt_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.req_type    (req_type),
		.key         (key),
		.payload     (payload),
		.status      (status),
		.entry_count (entry_count)
	);

	// An accepted item always occupies the following cycle.
	`SKT_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted item did not raise busy")
	// Every busy cycle is followed by exactly one result strobe.
	`SKT_ASSERT(a_busy_done, busy |=> done, "busy cycle not followed by a result")
	// A successful insert grows the count by one over the previous result.
	`SKT_ASSERT(a_insert_count,
		(done && status == ST_INSERTED) |->
			(entry_count == COUNT_W'($past(entry_count) + COUNT_W'(1))),
		"insert did not increment the entry count")
	// A full status is only reported with the table at capacity.
	`SKT_ASSERT(a_full_count, (done && status == ST_FULL) |-> (entry_count == COUNT_W'(CAPACITY)),
		"full status with the table below capacity")

endmodule

[rtl/core/skt_ctrl.sv]
// Controller state machine of the sorted key table.
module skt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output skt_pkg::skt_cmd_t cmd
);
	import skt_pkg::*;

	localparam logic S_IDLE  = 1'b0;
	localparam logic S_APPLY = 1'b1;

	logic state_q;
	logic state_d;
	logic done_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_APPLY;
				end
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.apply;
		end
	end

	assign busy = (state_q == S_APPLY);
	assign done = done_q;

endmodule

[rtl/core/skt_datapath.sv]
// Register array, compare masks and shift logic of the sorted key table.
module skt_datapath #(
	parameter int CAPACITY = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  skt_pkg::skt_cmd_t               cmd,
	input  logic                            req_type,
	input  logic [skt_pkg::KEY_W-1:0]       key,
	input  logic [skt_pkg::PAYLOAD_W-1:0]   payload,
	output logic [skt_pkg::STATUS_W-1:0]    status,
	output logic [skt_pkg::COUNT_W-1:0]     entry_count
);
	import skt_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	logic [KEY_W-1:0]     key_q [CAPACITY];
	logic [PAYLOAD_W-1:0] pay_q [CAPACITY];
	logic [CW-1:0]        count_q;

	logic                 req_s1;
	logic [KEY_W-1:0]     key_s1;
	logic [PAYLOAD_W-1:0] pay_s1;
	logic [CAPACITY-1:0]  lt_s1;
	logic [CAPACITY-1:0]  eq_s1;

	logic [CAPACITY-1:0]  bnd;
	logic                 full;
	logic                 empty;
	logic                 found;
	logic                 do_ins;
	logic                 do_del;
	logic [CW-1:0]        count_d;
	logic [STATUS_W-1:0]  status_d;
	logic [CW+COUNT_W-1:0] count_ext;

	logic [STATUS_W-1:0]  status_q;
	logic [COUNT_W-1:0]   entry_count_q;

	// Per entry compares against the incoming key, taken at acceptance.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
		logic valid;
		assign valid = (CW'(i) < count_q);

		always_ff @(posedge clk) begin
			if (cmd.capture) begin
				lt_s1[i] <= valid && (key_q[i] < key);
				eq_s1[i] <= valid && (key_q[i] == key);
			end
		end

		// The stored keys are sorted, so the less-than mask is a thermometer and
		// its edge marks both the insert position and the first possible match.
		if (i == 0) begin : g_b0
			assign bnd[i] = !lt_s1[i];
		end else begin : g_bn
			assign bnd[i] = !lt_s1[i] && lt_s1[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_s1 <= req_type;
			key_s1 <= key;
			pay_s1 <= payload;
		end
	end

	assign full   = (count_q == CW'(CAPACITY));
	assign empty  = (count_q == '0);
	assign found  = |(bnd & eq_s1);
	assign do_ins = cmd.apply && (req_s1 == REQ_INSERT) && !full;
	assign do_del = cmd.apply && (req_s1 == REQ_DELETE) && found;

	always_comb begin
		count_d  = count_q;
		status_d = ST_INSERTED;
		if (req_s1 == REQ_INSERT) begin
			if (full) begin
				status_d = ST_FULL;
			end else begin
				status_d = ST_INSERTED;
				count_d  = count_q + CW'(1);
			end
		end else begin
			if (empty) begin
				status_d = ST_EMPTY;
			end else if (found) begin
				status_d = ST_DELETED;
				count_d  = count_q - CW'(1);
			end else begin
				status_d = ST_NOT_FOUND;
			end
		end
	end

	// Entries below the edge stay; the rest move one place up or down.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (do_ins && !lt_s1[i]) begin
				if (bnd[i]) begin
					key_q[i] <= key_s1;
					pay_q[i] <= pay_s1;
				end else if (i > 0) begin
					key_q[i] <= key_q[(i > 0) ? i - 1 : 0];
					pay_q[i] <= pay_q[(i > 0) ? i - 1 : 0];
				end
			end else if (do_del && !lt_s1[i] && (i < CAPACITY - 1)) begin
				key_q[i] <= key_q[(i < CAPACITY - 1) ? i + 1 : i];
				pay_q[i] <= pay_q[(i < CAPACITY - 1) ? i + 1 : i];
			end
		end
	end

	assign count_ext = {{COUNT_W{1'b0}}, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			status_q      <= ST_INSERTED;
			entry_count_q <= '0;
		end else if (cmd.apply) begin
			count_q       <= count_d;
			status_q      <= status_d;
			entry_count_q <= count_ext[COUNT_W-1:0];
		end
	end

	assign status      = status_q;
	assign entry_count = entry_count_q;

endmodule

[tb/sv/tb_sorted_key_table.sv]
// Self-checking testbench of the sorted key table with a queue-fed driver and a checking monitor.
module tb_sorted_key_table;
	import skt_pkg::*;

	localparam int CAPACITY   = 64;
	// Cycles without any accepted item or result before the run is declared hung.
	localparam int HANG_LIMIT = 2000;
	// Cycles to wait after the last result.
	localparam int DRAIN_WAIT = 10;

	// One request as queued for the driver, with the chance per cycle
	// that the sender idles instead of offering it.
	typedef struct packed {
		logic                 req;
		logic [KEY_W-1:0]     key;
		logic [PAYLOAD_W-1:0] payload;
		logic [6:0]           idle_pct;
	} request_t;

	// What the table should answer to one request.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
	} outcome_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 start       = 1'b0;
	logic                 req_type    = 1'b0;
	logic [KEY_W-1:0]     key         = '0;
	logic [PAYLOAD_W-1:0] payload     = '0;
	logic                 busy;
	logic                 done;
	logic [STATUS_W-1:0]  status;
	logic [COUNT_W-1:0]   entry_count;

	sorted_key_table #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.key        (key),
		.payload    (payload),
		.done       (done),
		.status     (status),
		.entry_count(entry_count)
	);

	// Requests waiting to be offered, and the outcomes still owed by the table.
	request_t request_q[$];
	outcome_t outcome_q[$];

	// Mirror of the table contents, updated as each item is accepted.
	logic [KEY_W-1:0]     mirror_key[CAPACITY];
	logic [PAYLOAD_W-1:0] mirror_payload[CAPACITY];
	int                   mirror_count = 0;

	// Shadow of the key multiset used only by the stimulus generator, so that
	// deletes can target keys that will really be present.
	logic [KEY_W-1:0] gen_keys[$];

	logic item_taken   = 1'b0;
	int   errors       = 0;
	int   hang_cycles  = 0;
	int   items_done   = 0;
	int   peak_count   = 0;
	int   status_seen[5];

	initial begin
		forever #5 clk = ~clk;
	end

	// Applies one request to the mirror and returns the status and count that
	// the table must report. An insert goes ahead of the first key that is
	// greater than or equal to the new one, so a fresh duplicate lands in
	// front of older equal keys. A delete removes the lowest matching entry.
	function automatic outcome_t apply_request(input logic req, input logic [KEY_W-1:0] k,
		input logic [PAYLOAD_W-1:0] p);
		outcome_t o;
		int       pos;
		int       i;
		pos = 0;
		if (req == REQ_INSERT) begin
			if (mirror_count >= CAPACITY) begin
				// Full table: the insert is dropped and the table stays as it is.
				o.status = ST_FULL;
			end else begin
				while (pos < mirror_count && mirror_key[pos] < k)
					pos++;
				for (i = mirror_count; i > pos; i--) begin
					mirror_key[i]     = mirror_key[i-1];
					mirror_payload[i] = mirror_payload[i-1];
				end
				mirror_key[pos]     = k;
				mirror_payload[pos] = p;
				mirror_count++;
				o.status = ST_INSERTED;
			end
		end else if (mirror_count == 0) begin
			o.status = ST_EMPTY;
		end else begin
			while (pos < mirror_count && mirror_key[pos] != k)
				pos++;
			if (pos >= mirror_count) begin
				o.status = ST_NOT_FOUND;
			end else begin
				for (i = pos; i + 1 < mirror_count; i++) begin
					mirror_key[i]     = mirror_key[i+1];
					mirror_payload[i] = mirror_payload[i+1];
				end
				mirror_count--;
				o.status = ST_DELETED;
			end
		end
		o.count = COUNT_W'(mirror_count);
		return o;
	endfunction

	// Queues an insert and tracks it in the generator's key shadow.
	function automatic void queue_insert(input logic [KEY_W-1:0] k, input int pct);
		request_t r;
		r = '{req: REQ_INSERT, key: k, payload: $urandom, idle_pct: 7'(pct)};
		request_q.push_back(r);
		if (gen_keys.size() < CAPACITY)
			gen_keys.push_back(k);
	endfunction

	// Queues a delete and drops the first matching key from the shadow.
	function automatic void queue_delete(input logic [KEY_W-1:0] k, input int pct);
		request_t r;
		int       i;
		r = '{req: REQ_DELETE, key: k, payload: $urandom, idle_pct: 7'(pct)};
		request_q.push_back(r);
		for (i = 0; i < gen_keys.size(); i++) begin
			if (gen_keys[i] == k) begin
				gen_keys.delete(i);
				break;
			end
		end
	endfunction

	// Keys near the ends of the range, where ordering mistakes tend to hide.
	function automatic logic [KEY_W-1:0] edge_key();
		case ($urandom_range(3))
			0:       return '0;
			1:       return KEY_W'(1);
			2:       return '1;
			default: return {{(KEY_W-1){1'b1}}, 1'b0};
		endcase
	endfunction

	// Driver: offers the front request at the falling edge and holds it until
	// the monitor has seen it accepted. While idle the data pins carry noise.
	always @(negedge clk) begin : drive
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || item_taken) begin
			if (request_q.size() != 0 && $urandom_range(99) >= request_q[0].idle_pct) begin
				start    <= 1'b1;
				req_type <= request_q[0].req;
				key      <= request_q[0].key;
				payload  <= request_q[0].payload;
			end else begin
				start    <= 1'b0;
				req_type <= 1'($urandom);
				key      <= $urandom;
				payload  <= $urandom;
			end
		end
	end

	// Monitor: checks a result against the oldest outcome first, then predicts
	// any item accepted at the same edge, since the table may take a new item
	// in the very cycle that it reports the previous one.
	always @(posedge clk) begin : watch
		outcome_t want;
		if (arst_n) begin
			if (done) begin
				if (outcome_q.size() == 0) begin
					$error("result with nothing outstanding: status %0d entry_count %0d",
						status, entry_count);
					errors++;
				end else begin
					want = outcome_q.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						errors++;
					end
					if (entry_count !== want.count) begin
						$error("entry_count: expected %0d, got %0d", want.count, entry_count);
						errors++;
					end
					status_seen[want.status]++;
					if (int'(want.count) > peak_count)
						peak_count = int'(want.count);
					items_done++;
				end
			end
			if (start && !busy) begin
				outcome_q.push_back(apply_request(req_type, key, payload));
				request_q.delete(0);
			end
			item_taken <= start && !busy;

			// A hung table shows up as a long stretch with no traffic at all.
			if ((start && !busy) || done) begin
				hang_cycles <= 0;
			end else if (hang_cycles >= HANG_LIMIT) begin
				$display("sorted_key_table: mismatch");
				$finish;
			end else begin
				hang_cycles <= hang_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int idle_pct[4];
		int phase;
		int made;
		int mode;
		int run;
		int roll;
		logic [KEY_W-1:0] k;

		// Sender idle chance per phase: none, heavy, none again (the receiver
		// cannot stall, so its phase runs at full rate), and light.
		idle_pct = '{0, 77, 0, 31};

		// Directed opening: empty-table delete, both key extremes, a duplicate
		// that must go ahead of the older one, absent keys and draining back
		// to empty, then a delete on the empty table once more and a last short fill and drain.
		queue_delete('0, 0);
		queue_insert('0, 0);
		queue_insert('1, 0);
		queue_insert('0, 0);
		queue_insert(32'h8000_0000, 0);
		queue_insert(32'h7FFF_FFFF, 0);
		queue_insert('1, 0);
		queue_delete(32'h1234_5678, 0);
		queue_delete('1, 0);
		queue_delete('0, 0);
		queue_delete(32'h8000_0000, 0);
		queue_delete('0, 0);
		queue_delete('0, 0);
		queue_delete(32'h7FFF_FFFF, 0);
		queue_delete('1, 0);
		queue_delete('1, 0);
		queue_insert(32'h5555_5555, 0);
		queue_insert(32'hAAAA_AAAA, 0);
		queue_delete(32'hAAAA_AAAA, 0);
		queue_delete(32'h5555_5555, 0);

		// Random part: runs that lean toward filling, draining or a mix, so the
		// table swings between empty and full and both special statuses recur.
		for (phase = 0; phase < 4; phase++) begin
			made = 0;
			while (made < 425) begin
				mode = $urandom_range(2);
				run  = $urandom_range(20, 90);
				if (run > 425 - made)
					run = 425 - made;
				repeat (run) begin
					roll = $urandom_range(99);
					if ((mode == 0 && roll < 85) || (mode == 1 && roll < 15) ||
						(mode == 2 && roll < 50)) begin
						roll = $urandom_range(99);
						if (roll < 35)
							k = KEY_W'($urandom_range(15));
						else if (roll < 55 && gen_keys.size() != 0)
							k = gen_keys[$urandom_range(gen_keys.size() - 1)];
						else if (roll < 65)
							k = edge_key();
						else
							k = $urandom;
						queue_insert(k, idle_pct[phase]);
					end else begin
						roll = $urandom_range(99);
						if (roll < 65 && gen_keys.size() != 0)
							k = gen_keys[$urandom_range(gen_keys.size() - 1)];
						else if (roll < 80)
							k = KEY_W'($urandom_range(15));
						else if (roll < 90)
							k = edge_key();
						else
							k = $urandom;
						queue_delete(k, idle_pct[phase]);
					end
					made++;
				end
			end
		end

		// Single reset at the start, released away from the sampling edge.
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (request_q.size() != 0 || outcome_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Checked %0d items; inserted %0d, deleted %0d, not found %0d, empty %0d, full %0d.",
			items_done, status_seen[0], status_seen[1], status_seen[2], status_seen[3],
			status_seen[4]);
		$display("Highest entry count reported: %0d of %0d.", peak_count, CAPACITY);
		if (errors == 0)
			$display("sorted_key_table: match");
		else
			$display("sorted_key_table: mismatch");
		$finish;
	end

endmodule
